// ----- hdl/b2d_pkg.sv -----
// ----------------------------------------------------------------------------
// b2d_pkg
// Shared types and constants of the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2d_pkg;

    localparam int VALUE_W   = 31;
    localparam int IN_DATA_W = 32;
    localparam int CHAR_W    = 6;
    localparam int OUT_DATA_W = 8;
    localparam int DIGIT_W   = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
    localparam logic [31:0]       RECIP_TEN  = 32'hCCCC_CCCD;
    localparam int                RECIP_SHIFT = 35;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic               is_zero;
        logic [VALUE_W-1:0] value;
    } t_item;

endpackage

// ----- hdl/b2d_front.sv -----
// ----------------------------------------------------------------------------
// b2d_front
// Input stage: accepts items, marks the value zero, and hands them on.
// ----------------------------------------------------------------------------
module b2d_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [b2d_pkg::IN_DATA_W-1:0] i_s_tdata,
    output logic                          o_valid,
    input  logic                          i_ready,
    output b2d_pkg::t_item                o_item
);
    import b2d_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  w_take;

    assign o_s_tready = !r_valid || i_ready;
    assign w_take     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.value   <= i_s_tdata[VALUE_W-1:0];
            r_item.is_zero <= (i_s_tdata[VALUE_W-1:0] == '0);
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- hdl/b2d_queue.sv -----
// ----------------------------------------------------------------------------
// b2d_queue
// Short first-in first-out queue between the input stage and the converter.
// ----------------------------------------------------------------------------
module b2d_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  b2d_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output b2d_pkg::t_item o_item
);
    import b2d_pkg::*;

    t_item                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_AW:0]     r_count;
    logic                 w_push;
    logic                 w_pop;

    assign o_ready = (r_count != FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + (FIFO_AW+1)'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - (FIFO_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ----- hdl/b2d_back.sv -----
// ----------------------------------------------------------------------------
// b2d_back
// Converter: divides by ten one digit at a time into a digit store, then
// sends the digits most significant first as ASCII codes.
// ----------------------------------------------------------------------------
module b2d_back #(
    parameter int MAX_DIGITS = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  b2d_pkg::t_item                 i_item,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [b2d_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                           o_m_tlast
);
    import b2d_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIG  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]         r_state;
    logic [VALUE_W-1:0] r_rest;
    logic [63:0]        r_prod;
    logic [CNT_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   r_pos;
    logic [DIGIT_W-1:0] r_store [MAX_DIGITS];

    logic [VALUE_W-1:0] w_quot;
    logic [VALUE_W-1:0] w_times_ten;
    logic [DIGIT_W-1:0] w_rem;
    logic [CNT_W-1:0]   w_cnt_inc;
    logic               w_out_take;

    assign w_quot      = VALUE_W'(r_prod >> RECIP_SHIFT);
    assign w_times_ten = (w_quot << 3) + (w_quot << 1);
    assign w_rem       = DIGIT_W'(r_rest - w_times_ten);
    assign w_cnt_inc   = r_cnt + CNT_W'(1);
    assign w_out_take  = o_m_tvalid && i_m_tready;

    assign o_ready    = (r_state == S_IDLE);
    assign o_m_tvalid = (r_state == S_EMIT);
    assign o_m_tdata  = OUT_DATA_W'(ASCII_ZERO + CHAR_W'(r_store[r_pos]));
    assign o_m_tlast  = (r_pos == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cnt <= '0;
                        if (i_item.is_zero) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_state <= S_DIG;
                end
                S_DIG: begin
                    r_cnt <= w_cnt_inc;
                    if (w_quot == '0 || w_cnt_inc == CNT_W'(MAX_DIGITS)) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_EMIT: begin
                    if (w_out_take && r_pos == '0) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_rest <= i_item.value;
            r_pos  <= '0;
            if (i_item.is_zero) begin
                r_store[0] <= '0;
            end
        end
        if (r_state == S_MUL) begin
            r_prod <= {{(32 - VALUE_W){1'b0}}, r_rest} * RECIP_TEN;
        end
        if (r_state == S_DIG) begin
            r_store[r_cnt[IDX_W-1:0]] <= w_rem;
            r_rest <= w_quot;
            r_pos  <= r_cnt[IDX_W-1:0];
        end
        if (r_state == S_EMIT && w_out_take && r_pos != '0) begin
            r_pos <= r_pos - IDX_W'(1);
        end
    end

endmodule

// ----- hdl/binary_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts a non-negative binary integer to its decimal ASCII digits.
//
// The slave channel takes one item per integer: bits 30:0 of i_s_tdata hold
// the value. The master channel sends one item per decimal digit, most
// significant first: o_m_tdata bits 5:0 carry the ASCII code '0' to '9' and
// o_m_tlast marks the least significant, final digit. Zero gives one '0'.
// An input stage and a two-entry queue take items while the converter works.
// The converter takes an item in its idle state, then for each digit multiplies
// by the reciprocal of ten and then forms the remainder, and sends one digit
// per cycle when the receiver is ready. It takes no new item until the last
// digit is sent. Zero skips the division.
// Only the MAX_DIGITS least significant digits are kept.
// Reset clears the input stage, the queue and the converter state.
// When the receiver stalls, the current digit holds and new items back up
// into the queue and then the input stage.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii #(
    parameter int MAX_DIGITS = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [b2d_pkg::IN_DATA_W-1:0]  i_s_tdata,   // value[30:0], pad[31]
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [b2d_pkg::OUT_DATA_W-1:0] o_m_tdata,   // digit_char[5:0], pad[7:6]
    output logic                           o_m_tlast
);
    import b2d_pkg::*;

    logic  w_fr_valid;
    logic  w_fr_ready;
    t_item w_fr_item;
    logic  w_q_valid;
    logic  w_q_ready;
    t_item w_q_item;

    b2d_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_valid    (w_fr_valid),
        .i_ready    (w_fr_ready),
        .o_item     (w_fr_item)
    );

    b2d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .o_ready (w_fr_ready),
        .i_item  (w_fr_item),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_item  (w_q_item)
    );

    b2d_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .o_ready    (w_q_ready),
        .i_item     (w_q_item),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Sends binary integers into binary_to_decimal_ascii and checks every decimal
// digit that comes back, field by field, against digits worked out here from
// each accepted value or given in a table. A short table of edge values comes
// first, then several hundred random values spread over all digit counts, with
// bursty input traffic, a receiver that stalls in changing patterns, and one
// long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench;
    import b2d_pkg::*;

    localparam int MAX_DIGITS  = 10;
    localparam int RANDOM_N    = 470;
    localparam int DIR_N       = 15;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_WAIT  = 40;

    typedef struct {
        logic [CHAR_W-1:0] char_code;
        logic              last_digit;
    } t_digit;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;   // value[30:0], pad[31]
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;         // digit_char[5:0], pad[7:6]
    logic                  o_m_tlast;

    t_digit pending_digits[$];
    t_digit wanted;
    int     error_count = 0;
    int     cycle_count = 0;
    int     input_accepts = 0;
    int     hold_left = 0;
    bit     hold_done = 1'b0;
    int     ready_mode = 0;
    int     mode_cycles = 0;
    int     burst_left = 0;

    logic [IN_DATA_W-1:0] dir_value [DIR_N];
    string                dir_text  [DIR_N];

    binary_to_decimal_ascii #(
        .MAX_DIGITS(MAX_DIGITS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast)
    );

    always #10 i_clk = ~i_clk;

    function automatic void push_decimal_digits(input logic [IN_DATA_W-1:0] data);
        logic [VALUE_W-1:0] rest;
        logic [3:0]         digits [MAX_DIGITS];
        int                 count;
        t_digit             d;
        rest  = data[VALUE_W-1:0];
        count = 0;
        if (rest == '0) begin
            digits[0] = 4'd0;
            count     = 1;
        end else begin
            while (rest != '0 && count < MAX_DIGITS) begin
                digits[count] = 4'(rest % 31'd10);
                rest          = rest / 31'd10;
                count++;
            end
        end
        for (int k = count - 1; k >= 0; k--) begin
            d.char_code  = ASCII_ZERO + CHAR_W'(digits[k]);
            d.last_digit = (k == 0);
            pending_digits.push_back(d);
        end
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_value();
        int          digits;
        longint      lo;
        longint      hi;
        logic [30:0] raw;
        if ($urandom_range(0, 3) == 0) begin
            raw = 31'($urandom);
            return {1'b0, raw};
        end
        digits = $urandom_range(1, 10);
        lo     = 1;
        repeat (digits - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (digits == 1) lo = 0;
        if (hi > 64'd2147483647) hi = 64'd2147483647;
        return IN_DATA_W'($urandom_range(32'(hi), 32'(lo)));
    endfunction

    // An empty text means the expected digits come from the predictor.
    task automatic offer_value(input logic [IN_DATA_W-1:0] data, input string text,
                               input int gap);
        t_digit d;
        byte    c;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        do @(posedge i_clk); while (!o_s_tready);
        if (text.len() == 0) begin
            push_decimal_digits(data);
        end else begin
            for (int i = 0; i < text.len(); i++) begin
                c            = text[i];
                d.char_code  = c[CHAR_W-1:0];
                d.last_digit = (i == text.len() - 1);
                pending_digits.push_back(d);
            end
        end
    endtask

    initial begin
        int gap;
        dir_value = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd2147483647,
                      32'd1000000000, 32'd999999999, 32'h8000_3039, 32'h2AAA_AAAA,
                      32'h5555_5555, 32'd65536, 32'hFFFF_FFFF, 32'd0};
        dir_text  = '{"0", "1", "9", "10", "", "", "2147483647",
                      "1000000000", "999999999", "12345", "",
                      "", "", "2147483647", "0"};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < DIR_N; i++) begin
            offer_value(dir_value[i], dir_text[i], 0);
        end
        for (int i = 0; i < RANDOM_N; i++) begin
            gap = 0;
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 25);
                burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 20);
            end
            burst_left--;
            offer_value(random_value(), "", gap);
        end
        i_s_tvalid <= 1'b0;
        while (pending_digits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("** binary_to_decimal_ascii: PASSED **");
        end else begin
            $display("** binary_to_decimal_ascii: FAILED **");
        end
        $finish;
    end

    // The receiver holds off once for a long stretch after a number of inputs.
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            input_accepts <= input_accepts + 1;
        end
        if (!hold_done && input_accepts == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_digits.size() == 0) begin
                $display("%0t: unexpected digit item, expected none, actual char %0d last %0b",
                         $time, o_m_tdata[CHAR_W-1:0], o_m_tlast);
                error_count++;
            end else begin
                wanted = pending_digits.pop_front();
                if (o_m_tdata[CHAR_W-1:0] !== wanted.char_code) begin
                    $display("%0t: digit_char mismatch, expected %0d, actual %0d",
                             $time, wanted.char_code, o_m_tdata[CHAR_W-1:0]);
                    error_count++;
                end
                if (o_m_tlast !== wanted.last_digit) begin
                    $display("%0t: last_digit mismatch, expected %0b, actual %0b",
                             $time, wanted.last_digit, o_m_tlast);
                    error_count++;
                end
            end
        end
        if (mode_cycles == 0) begin
            ready_mode  <= $urandom_range(0, 3);
            mode_cycles <= $urandom_range(20, 200);
        end else begin
            mode_cycles <= mode_cycles - 1;
        end
        case (ready_mode)
            0: i_m_tready <= (hold_left == 0);
            1: i_m_tready <= (hold_left == 0) && ($urandom_range(0, 3) != 0);
            2: i_m_tready <= (hold_left == 0) && ($urandom_range(0, 1) != 0);
            default: i_m_tready <= (hold_left == 0) && ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d digits still expected", $time,
                     pending_digits.size());
            $display("** binary_to_decimal_ascii: FAILED **");
            $finish;
        end
    end

endmodule
